// File: src/yfs_pkg.sv
// Shared types, constants and helper functions for the frame statistics block.
package yfs_pkg;

    // Width of the running sums; totals are reported at 32 bits.
    localparam int SUM_BITS    = 32;
    localparam int SAMPLE_BITS = 8;
    localparam int OUT_BITS    = 32;

    // Depth of the queue between the front and back halves.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Component indexes into the per-component accumulators.
    localparam int NUM_COMP = 3;
    localparam logic [1:0] COMP_Y = 2'd0;
    localparam logic [1:0] COMP_U = 2'd1;
    localparam logic [1:0] COMP_V = 2'd2;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [OUT_BITS-1:0]    FRAME_FIRST = OUT_BITS'(1);

    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // One pixel as it arrives.
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] ref_luma;
        logic       chroma_present;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       end_of_frame;
    } pix_t;

    // One statistics record per frame.
    typedef struct packed {
        logic [31:0] frame_number;
        logic [7:0]  luma_min;
        logic [7:0]  luma_max;
        logic [31:0] luma_total;
        logic [7:0]  cb_min;
        logic [7:0]  cb_max;
        logic [31:0] cb_total;
        logic [7:0]  cr_min;
        logic [7:0]  cr_max;
        logic [31:0] cr_total;
        logic [31:0] luma_abs_diff_total;
    } stats_t;

    // Classified pixel held in the queue: difference already worked out.
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] abs_diff;
        logic       chroma_present;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       end_of_frame;
    } work_t;

    // Queue status seen by both halves.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Add a sample to a running sum, sticking at all ones.
    function automatic sum_t sat_add(sum_t acc, sample_t v);
        logic [SUM_BITS:0] s;
        s = {1'b0, acc} + (SUM_BITS+1)'(v);
        return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
    endfunction

    // Clamp a running sum to the 32-bit reported total.
    function automatic logic [OUT_BITS-1:0] sat_out(sum_t v);
        return (64'(v) > 64'hFFFF_FFFF) ? '1 : OUT_BITS'(v);
    endfunction

endpackage

// File: src/yfs_front.sv
// Front half: register each pixel and classify it into a queue entry.
module yfs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  yfs_pkg::pix_t     pix,
    input  yfs_pkg::q_status_t q_status,
    output logic              push,
    output yfs_pkg::work_t    work
);

    logic           valid_reg;
    yfs_pkg::work_t work_reg;
    yfs_pkg::work_t work_next;

    // Hold the pixel while the queue is full.
    assign pix_stall = valid_reg && q_status.full;
    assign push      = valid_reg && !q_status.full;
    assign work      = work_reg;

    // Work out the absolute luma difference on the way in.
    always_comb
    begin
        work_next.luma           = pix.luma;
        work_next.abs_diff       = (pix.luma >= pix.ref_luma) ? (pix.luma - pix.ref_luma)
                                                              : (pix.ref_luma - pix.luma);
        work_next.chroma_present = pix.chroma_present;
        work_next.cb             = pix.cb;
        work_next.cr             = pix.cr;
        work_next.end_of_frame   = pix.end_of_frame;
    end

    // Advance the front register on every transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!pix_stall)
        begin
            valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid && !pix_stall)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// File: src/yfs_queue.sv
// Short queue of classified pixels between the front and back halves.
module yfs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  yfs_pkg::work_t     push_data,
    input  logic               pop,
    output yfs_pkg::work_t     head,
    output yfs_pkg::q_status_t q_status
);

    yfs_pkg::work_t                 entry_reg [yfs_pkg::QUEUE_DEPTH];
    logic [yfs_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [yfs_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [yfs_pkg::QPTR_BITS:0]    count_reg;
    logic [yfs_pkg::QPTR_BITS:0]    count_next;
    logic                           do_push;
    logic                           do_pop;

    assign q_status.full  = (count_reg == (yfs_pkg::QPTR_BITS+1)'(yfs_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = entry_reg[rd_ptr_reg];

    // Track the fill level.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Write the new entry.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/yfs_back.sv
// Back half: update the frame accumulators and issue one record per frame.
module yfs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  yfs_pkg::work_t     head,
    input  yfs_pkg::q_status_t q_status,
    output logic               pop,
    output logic               stats_valid,
    input  logic               stats_stall,
    output yfs_pkg::stats_t    stats
);

    logic [yfs_pkg::OUT_BITS-1:0] frame_reg;
    yfs_pkg::sample_t             min_reg  [yfs_pkg::NUM_COMP];
    yfs_pkg::sample_t             max_reg  [yfs_pkg::NUM_COMP];
    yfs_pkg::sum_t                sum_reg  [yfs_pkg::NUM_COMP];
    yfs_pkg::sum_t                diff_reg;
    yfs_pkg::sample_t             min_next [yfs_pkg::NUM_COMP];
    yfs_pkg::sample_t             max_next [yfs_pkg::NUM_COMP];
    yfs_pkg::sum_t                sum_next [yfs_pkg::NUM_COMP];
    yfs_pkg::sum_t                diff_next;
    yfs_pkg::sample_t             sample   [yfs_pkg::NUM_COMP];
    logic                         take     [yfs_pkg::NUM_COMP];
    logic                         out_valid_reg;
    yfs_pkg::stats_t              out_reg;
    yfs_pkg::stats_t              out_next;
    logic                         finish;

    // Take the head unless it closes a frame and the record slot is blocked.
    assign pop    = !q_status.empty
                    && (!head.end_of_frame || !out_valid_reg || !stats_stall);
    assign finish = pop && head.end_of_frame;

    assign stats_valid = out_valid_reg;
    assign stats       = out_reg;

    // Fold the head pixel into each component.
    always_comb
    begin
        sample[yfs_pkg::COMP_Y] = head.luma;
        sample[yfs_pkg::COMP_U] = head.cb;
        sample[yfs_pkg::COMP_V] = head.cr;
        take[yfs_pkg::COMP_Y]   = 1'b1;
        take[yfs_pkg::COMP_U]   = head.chroma_present;
        take[yfs_pkg::COMP_V]   = head.chroma_present;
        for (int c = 0; c < yfs_pkg::NUM_COMP; c++)
        begin
            min_next[c] = min_reg[c];
            max_next[c] = max_reg[c];
            sum_next[c] = sum_reg[c];
            if (take[c])
            begin
                if (sample[c] < min_reg[c])
                begin
                    min_next[c] = sample[c];
                end
                if (sample[c] > max_reg[c])
                begin
                    max_next[c] = sample[c];
                end
                sum_next[c] = yfs_pkg::sat_add(sum_reg[c], sample[c]);
            end
        end
        diff_next = yfs_pkg::sat_add(diff_reg, head.abs_diff);
    end

    // Assemble the frame record from the updated totals.
    always_comb
    begin
        out_next.frame_number        = frame_reg;
        out_next.luma_min            = min_next[yfs_pkg::COMP_Y];
        out_next.luma_max            = max_next[yfs_pkg::COMP_Y];
        out_next.luma_total          = yfs_pkg::sat_out(sum_next[yfs_pkg::COMP_Y]);
        out_next.cb_min              = min_next[yfs_pkg::COMP_U];
        out_next.cb_max              = max_next[yfs_pkg::COMP_U];
        out_next.cb_total            = yfs_pkg::sat_out(sum_next[yfs_pkg::COMP_U]);
        out_next.cr_min              = min_next[yfs_pkg::COMP_V];
        out_next.cr_max              = max_next[yfs_pkg::COMP_V];
        out_next.cr_total            = yfs_pkg::sat_out(sum_next[yfs_pkg::COMP_V]);
        out_next.luma_abs_diff_total = yfs_pkg::sat_out(diff_next);
    end

    // Update accumulators; clear them and advance the frame count at end of frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= yfs_pkg::FRAME_FIRST;
            diff_reg  <= '0;
            for (int c = 0; c < yfs_pkg::NUM_COMP; c++)
            begin
                min_reg[c] <= yfs_pkg::SAMPLE_MAX;
                max_reg[c] <= '0;
                sum_reg[c] <= '0;
            end
        end
        else if (pop)
        begin
            if (head.end_of_frame)
            begin
                frame_reg <= (frame_reg == '1) ? yfs_pkg::FRAME_FIRST : frame_reg + 1'b1;
                diff_reg  <= '0;
                for (int c = 0; c < yfs_pkg::NUM_COMP; c++)
                begin
                    min_reg[c] <= yfs_pkg::SAMPLE_MAX;
                    max_reg[c] <= '0;
                    sum_reg[c] <= '0;
                end
            end
            else
            begin
                diff_reg <= diff_next;
                for (int c = 0; c < yfs_pkg::NUM_COMP; c++)
                begin
                    min_reg[c] <= min_next[c];
                    max_reg[c] <= max_next[c];
                    sum_reg[c] <= sum_next[c];
                end
            end
        end
    end

    // Hold the record until its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!stats_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: src/yuv_frame_statistics.sv
// Top level of the per-frame YUV statistics block.
// Takes one pixel per clock in raster order while pix_stall is low and, on the pixel
// flagged end_of_frame, issues one record with the frame number (first frame is 1), the
// minimum, maximum and saturating 32-bit sum of Y, Cb and Cr, and the saturating sum of
// absolute luma differences to ref_luma; accumulators then clear. Chroma counts only
// where chroma_present is set. Sustained rate is one pixel per cycle while nothing
// stalls, set by the accumulator update in the back half; stats_valid rises once the
// pixel that closes a frame has passed the input register, the queue and the record
// register. A four-entry queue between the input register and the accumulators lets
// pixels keep flowing while a finished record waits on stats_stall; only a pixel that
// closes a frame waits for the record register to drain.
module yuv_frame_statistics (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pix_valid,
    output logic            pix_stall,
    input  yfs_pkg::pix_t   pix,
    output logic            stats_valid,
    input  logic            stats_stall,
    output yfs_pkg::stats_t stats
);

    yfs_pkg::q_status_t q_status;
    yfs_pkg::work_t     work;
    yfs_pkg::work_t     head;
    logic               push;
    logic               pop;

    yfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .q_status  (q_status),
        .push      (push),
        .work      (work)
    );

    yfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (work),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    yfs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .stats_valid (stats_valid),
        .stats_stall (stats_stall),
        .stats       (stats)
    );

`ifndef NO_ASSERTIONS
    // The queue can never report full and empty together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty together");

    // A stalled input implies the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> q_status.full)
        else $error("input stalled with room in queue");

    // Every record covers at least one luma sample and a non-zero frame number.
    assert property (@(posedge clk) disable iff (!rst_n)
        stats_valid |-> (stats.luma_min <= stats.luma_max) && (stats.frame_number != 0))
        else $error("malformed frame record");

    // A queue entry is only popped when one is present.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking bench for the per-frame YUV statistics block: directed frames, then random streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 1200;
    localparam int DRAIN_CYCLES  = 16;

    // One row of the directed table: a pixel and, where typed in, its frame record.
    typedef struct packed {
        yfs_pkg::pix_t   px;
        logic            typed;
        yfs_pkg::stats_t rec;
    } dir_row_t;

    logic            clk;
    logic            rst_n;
    logic            pix_valid;
    logic            pix_stall;
    yfs_pkg::pix_t   pix;
    logic            stats_valid;
    logic            stats_stall;
    yfs_pkg::stats_t stats;

    // Own copy of the frame statistics; sums are held at 64 bits and clamped to the block's sum width.
    logic [31:0] frame_ctr;
    logic [7:0]  comp_min [3];
    logic [7:0]  comp_max [3];
    logic [63:0] comp_sum [3];
    logic [63:0] sad_sum;

    yfs_pkg::stats_t pending_stats [$];
    int              mismatch_count;
    bit              sender_steady;
    bit              receiver_steady;

    // Directed frames: extremes, no chroma, ignored chroma, differences both ways.
    dir_row_t directed_rows [13] = '{
        '{'{8'd0, 8'd16, 1'b1, 8'd0, 8'd255, 1'b1}, 1'b1,
          '{32'd1, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0, 32'd0, 8'd255, 8'd255, 32'd255, 32'd16}},
        '{'{8'd255, 8'd0, 1'b0, 8'hAA, 8'h55, 1'b1}, 1'b1,
          '{32'd2, 8'd255, 8'd255, 32'd255, 8'd255, 8'd0, 32'd0, 8'd255, 8'd0, 32'd0, 32'd255}},
        '{'{8'd255, 8'd255, 1'b1, 8'd255, 8'd0, 1'b0}, 1'b0, '0},
        '{'{8'd0, 8'd255, 1'b0, 8'd0, 8'd255, 1'b0}, 1'b0, '0},
        '{'{8'd128, 8'd100, 1'b1, 8'd1, 8'd254, 1'b1}, 1'b0, '0},
        '{'{8'd7, 8'd7, 1'b0, 8'hFF, 8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'd7, 8'd7, 1'b0, 8'h00, 8'h00, 1'b1}, 1'b1,
          '{32'd4, 8'd7, 8'd7, 32'd14, 8'd255, 8'd0, 32'd0, 8'd255, 8'd0, 32'd0, 32'd0}},
        '{'{8'd10, 8'd250, 1'b1, 8'd128, 8'd128, 1'b0}, 1'b0, '0},
        '{'{8'd250, 8'd10, 1'b1, 8'd127, 8'd129, 1'b1}, 1'b0, '0},
        '{'{8'h5A, 8'hA5, 1'b0, 8'h0F, 8'hF0, 1'b0}, 1'b0, '0},
        '{'{8'hA5, 8'h5A, 1'b1, 8'hF0, 8'h0F, 1'b1}, 1'b0, '0},
        '{'{8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 1'b1}, 1'b1,
          '{32'd7, 8'd255, 8'd255, 32'd255, 8'd255, 8'd255, 32'd255,
            8'd255, 8'd255, 32'd255, 32'd0}},
        '{'{8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 1'b1}, 1'b1,
          '{32'd8, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0, 32'd0, 32'd0}}
    };

    yuv_frame_statistics u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix         (pix),
        .stats_valid (stats_valid),
        .stats_stall (stats_stall),
        .stats       (stats)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Add to a running sum, sticking at the top of the sum width.
    function automatic logic [63:0] add_clamped(logic [63:0] acc, logic [63:0] v);
        logic [63:0] lim;
        lim = (64'd1 << yfs_pkg::SUM_BITS) - 64'd1;
        if (acc >= lim || v > lim - acc)
            return lim;
        return acc + v;
    endfunction

    function automatic logic [31:0] clamp32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void clear_frame();
        for (int c = 0; c < 3; c++)
        begin
            comp_min[c] = 8'd255;
            comp_max[c] = 8'd0;
            comp_sum[c] = 64'd0;
        end
        sad_sum = 64'd0;
    endfunction

    function automatic void fold_sample(logic [1:0] c, logic [7:0] s);
        if (s < comp_min[c])
            comp_min[c] = s;
        if (s > comp_max[c])
            comp_max[c] = s;
        comp_sum[c] = add_clamped(comp_sum[c], 64'(s));
    endfunction

    // Fold one pixel into the frame; on the last pixel hand back the frame record.
    function automatic bit accumulate_pixel(yfs_pkg::pix_t p, output yfs_pkg::stats_t rec);
        logic [7:0] diff;
        rec  = '0;
        diff = (p.luma >= p.ref_luma) ? p.luma - p.ref_luma : p.ref_luma - p.luma;
        fold_sample(yfs_pkg::COMP_Y, p.luma);
        sad_sum = add_clamped(sad_sum, 64'(diff));
        if (p.chroma_present)
        begin
            fold_sample(yfs_pkg::COMP_U, p.cb);
            fold_sample(yfs_pkg::COMP_V, p.cr);
        end
        if (!p.end_of_frame)
            return 1'b0;
        rec.frame_number        = frame_ctr;
        rec.luma_min            = comp_min[yfs_pkg::COMP_Y];
        rec.luma_max            = comp_max[yfs_pkg::COMP_Y];
        rec.luma_total          = clamp32(comp_sum[yfs_pkg::COMP_Y]);
        rec.cb_min              = comp_min[yfs_pkg::COMP_U];
        rec.cb_max              = comp_max[yfs_pkg::COMP_U];
        rec.cb_total            = clamp32(comp_sum[yfs_pkg::COMP_U]);
        rec.cr_min              = comp_min[yfs_pkg::COMP_V];
        rec.cr_max              = comp_max[yfs_pkg::COMP_V];
        rec.cr_total            = clamp32(comp_sum[yfs_pkg::COMP_V]);
        rec.luma_abs_diff_total = clamp32(sad_sum);
        clear_frame();
        // the frame number wraps to 1, never to 0
        frame_ctr = (frame_ctr == 32'hFFFF_FFFF) ? 32'd1 : frame_ctr + 32'd1;
        return 1'b1;
    endfunction

    function automatic int draw_gap(bit steady);
        return steady ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_sample(int mode, logic [7:0] base);
        case (mode)
            0:       return 8'($urandom_range(0, 255));
            1:       return $urandom_range(0, 1) ? 8'd255 - 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 3));
            default: return base + 8'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void compare_record(yfs_pkg::stats_t want, yfs_pkg::stats_t got);
        check_field("frame_number", want.frame_number, got.frame_number);
        check_field("luma_min", 32'(want.luma_min), 32'(got.luma_min));
        check_field("luma_max", 32'(want.luma_max), 32'(got.luma_max));
        check_field("luma_total", want.luma_total, got.luma_total);
        check_field("cb_min", 32'(want.cb_min), 32'(got.cb_min));
        check_field("cb_max", 32'(want.cb_max), 32'(got.cb_max));
        check_field("cb_total", want.cb_total, got.cb_total);
        check_field("cr_min", 32'(want.cr_min), 32'(got.cr_min));
        check_field("cr_max", 32'(want.cr_max), 32'(got.cr_max));
        check_field("cr_total", want.cr_total, got.cr_total);
        check_field("luma_abs_diff_total", want.luma_abs_diff_total, got.luma_abs_diff_total);
    endfunction

    // Present one pixel after a random gap and hold it until the transfer.
    task automatic send_pixel(input yfs_pkg::pix_t p, input logic typed,
                              input yfs_pkg::stats_t typed_rec);
        int              gap;
        yfs_pkg::stats_t rec;
        gap = draw_gap(sender_steady);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        if (accumulate_pixel(p, rec))
            pending_stats.push_back(typed ? typed_rec : rec);
        if ($urandom_range(0, 39) == 0)
            sender_steady = !sender_steady;
    endtask

    // Hold the input idle until every frame record has come out.
    task automatic drain_records();
        pix_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_stats.size() != 0);
    endtask

    // Accept records after random stalls and compare them with the oldest expectation.
    initial
    begin : record_sink
        int              gap;
        yfs_pkg::stats_t want;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(receiver_steady);
            if (gap > 0)
            begin
                stats_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            stats_stall <= 1'b0;
            @(posedge clk);
            while (!stats_valid)
                @(posedge clk);
            if (pending_stats.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, got frame %0d",
                         $time, stats.frame_number);
                mismatch_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                compare_record(want, stats);
            end
            if ($urandom_range(0, 39) == 0)
                receiver_steady = !receiver_steady;
        end
    end

    initial
    begin : stimulus
        yfs_pkg::pix_t p;
        int            sent;
        int            frame_len;
        int            len_pick;
        int            chroma_mode;
        int            value_mode;
        int            ref_mode;
        bit            paused;
        logic [7:0]    base;
        pix_valid       = 1'b0;
        pix             = '0;
        stats_stall     = 1'b0;
        rst_n           = 1'b0;
        mismatch_count  = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        paused          = 1'b0;
        sent            = 0;
        frame_ctr       = 32'd1;
        clear_frame();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (directed_rows[i])
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].rec);
        drain_records();

        // random frames, mostly short, a few long
        while (sent < RANDOM_PIXELS)
        begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 85)
                frame_len = $urandom_range(1, 24);
            else if (len_pick < 97)
                frame_len = $urandom_range(25, 80);
            else
                frame_len = $urandom_range(150, 300);
            // keep the last frame within the pixel budget
            if (frame_len > RANDOM_PIXELS - sent)
                frame_len = RANDOM_PIXELS - sent;
            chroma_mode = $urandom_range(0, 3);
            value_mode  = $urandom_range(0, 2);
            ref_mode    = $urandom_range(0, 3);
            base        = 8'($urandom_range(0, 255));
            for (int k = 0; k < frame_len; k++)
            begin
                p.luma = pick_sample(value_mode, base);
                p.cb   = pick_sample(value_mode, base ^ 8'h80);
                p.cr   = pick_sample(value_mode, ~base);
                case (ref_mode)
                    0:       p.ref_luma = 8'($urandom_range(0, 255));
                    1:       p.ref_luma = 8'd16;
                    2:       p.ref_luma = p.luma;
                    default: p.ref_luma = p.luma ^ 8'($urandom_range(0, 7));
                endcase
                case (chroma_mode)
                    0:       p.chroma_present = 1'b0;
                    1:       p.chroma_present = 1'b1;
                    2:       p.chroma_present = (k % 2 == 0);
                    default: p.chroma_present = 1'($urandom_range(0, 1));
                endcase
                p.end_of_frame = (k == frame_len - 1);
                send_pixel(p, 1'b0, '0);
                sent++;
            end
            // let the pipeline empty once mid-run
            if (!paused && sent >= RANDOM_PIXELS / 2)
            begin
                drain_records();
                paused = 1'b1;
            end
        end

        pix_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Abandon a hung run
    initial
    begin : watchdog
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// File: filelist.f
src/yfs_pkg.sv
src/yfs_front.sv
src/yfs_queue.sv
src/yfs_back.sv
src/yuv_frame_statistics.sv
bench/testbench.sv
